// File: src/bpa_pkg.sv
package bpa_pkg;

   localparam int WORD_BITS = 64;

   // actions
   localparam logic [1:0] ACT_INIT  = 2'd0;
   localparam logic [1:0] ACT_ALLOC = 2'd1;
   localparam logic [1:0] ACT_FREE  = 2'd2;
   localparam logic [1:0] ACT_NOP   = 2'd3;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_ZERO  = 2'd1;
   localparam logic [1:0] STAT_NOFIT = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_REGION_BASE = 2'd0;
   localparam logic [1:0] CSR_PAGE_COUNT  = 2'd1;
   localparam logic [1:0] CSR_FREE_FROM   = 2'd2;
   localparam logic [1:0] CSR_FREE_TO     = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] address;
      logic [12:0] count;
   } req_type;

   typedef struct packed {
      logic [63:0] result_address;
      logic [1:0]  status;
      logic [12:0] invalid_pages;
      logic [12:0] double_frees;
      logic [12:0] free_total;
   } rsp_type;

   typedef struct packed {
      logic [63:0] region_base;
      logic [12:0] page_count;
      logic [63:0] free_from_addr;
      logic [63:0] free_to_addr;
   } cfg_type;

endpackage

// File: src/bitmap_page_allocator.sv
// Bitmap first-fit page allocator.
// Request beats (req_valid / req_stall / req_payload) carry an action: init
// rebuilds the bitmap from the free_from / free_to registers, alloc takes the
// lowest run of count free pages, free releases count pages from an address,
// and nop changes nothing. Every request gives exactly one response beat
// (rsp_valid / rsp_stall / rsp_payload) with address, status, error counts and
// the free page count. One request is worked at a time; the bitmap lives in a
// single-port-read memory of MAX_PAGES/64 words, so the memory port sets the
// timing: init writes one word per cycle, alloc tests all-used or all-free
// words whole and mixed words bit by bit, then read-modify-writes each word of
// the chosen run, and free reads and updates one page at a time.
// The result is then registered in the response register. Configuration is
// written via csr_wr_en / csr_index / csr_wdata; the user must do so only while
// idle, which the block itself does not enforce. After reset the bitmap is set
// all used by a clearing pass, during which req_stall stays high. A stalled
// response holds in the output register; the next request is still taken and
// its result waits.
module bitmap_page_allocator #(
   parameter int MAX_PAGES = 4096,
   parameter int PAGE_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bpa_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bpa_pkg::rsp_type rsp_payload,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_wdata
);
   import bpa_pkg::*;

   localparam int WORDS = (MAX_PAGES + 63) / 64;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

   cfg_type       cfg_ff, cfg_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic          eng_ready, eng_res_valid, res_ok;
   rsp_type       eng_res;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [63:0]   rd_data, wr_data;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_REGION_BASE: cfg_in.region_base    = csr_wdata;
            CSR_PAGE_COUNT:  cfg_in.page_count     = csr_wdata[12:0];
            CSR_FREE_FROM:   cfg_in.free_from_addr = csr_wdata;
            CSR_FREE_TO:     cfg_in.free_to_addr   = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // response register: load a new beat, drop a taken one
   assign res_ok = !rsp_valid_ff || !rsp_stall;
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (eng_res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in = eng_res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign req_stall   = !eng_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   bpa_engine #(
      .MAX_PAGES(MAX_PAGES), .PAGE_BITS(PAGE_BITS), .WORDS(WORDS), .AW(AW)
   ) u_engine (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_valid(req_valid), .req(req_payload), .req_ready(eng_ready),
      .res_ok(res_ok), .res_valid(eng_res_valid), .res(eng_res),
      .mem_rd_en(rd_en), .mem_rd_addr(rd_addr), .mem_rd_data(rd_data),
      .mem_wr_en(wr_en), .mem_wr_addr(wr_addr), .mem_wr_data(wr_data)
   );

   bpa_map_ram #(.WORDS(WORDS), .AW(AW)) u_map (
      .clock(clock), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
   );

   // one request in flight at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while engine busy");

   // never overwrite a stalled response beat
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      eng_res_valid |-> !(rsp_valid_ff && rsp_stall))
      else $error("response overrun");

   // a failed or zero-count allocation returns address zero
   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != STAT_OK) |-> rsp_payload.result_address == 64'd0)
      else $error("nonzero address with error status");
endmodule

// File: src/bpa_map_ram.sv
module bpa_map_ram #(
   parameter int WORDS = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [63:0]   rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_data
);
   logic [63:0] map_ff [WORDS];
   logic [63:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= map_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: src/bpa_engine.sv
module bpa_engine #(
   parameter int MAX_PAGES = 4096,
   parameter int PAGE_BITS = 12,
   parameter int WORDS     = 64,
   parameter int AW        = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  bpa_pkg::cfg_type cfg,
   input  logic             req_valid,
   input  bpa_pkg::req_type req,
   output logic             req_ready,
   input  logic             res_ok,
   output logic             res_valid,
   output bpa_pkg::rsp_type res,
   output logic             mem_rd_en,
   output logic [AW-1:0]    mem_rd_addr,
   input  logic [63:0]      mem_rd_data,
   output logic             mem_wr_en,
   output logic [AW-1:0]    mem_wr_addr,
   output logic [63:0]      mem_wr_data
);
   import bpa_pkg::*;

   localparam int XW = AW + 7;
   localparam logic [63:0] PAGE_STRIDE = 64'(1) << PAGE_BITS;
   localparam logic [63:0] OFF_MASK    = PAGE_STRIDE - 64'd1;

   typedef enum logic [3:0] {
      S_IDLE, S_INIT0, S_INIT1, S_INIT2, S_INIT3, S_SWEEP, S_AEV, S_ABIT,
      S_MRD, S_MWR, S_FSUB, S_FCHK, S_FUPD, S_DONE
   } state_type;

   // clamp a page number to its offset inside the word starting at wb
   function automatic logic [6:0] kclamp(input logic [XW-1:0] x, input logic [XW-1:0] wb);
      logic [XW-1:0] dx;
      dx = x - wb;
      if (x <= wb) return 7'd0;
      else if (dx >= XW'(WORD_BITS)) return 7'd64;
      else return 7'(dx);
   endfunction

   function automatic logic [63:0] below(input logic [6:0] k);
      if (k[6]) return '1;
      else return (64'(1) << k[5:0]) - 64'd1;
   endfunction

   // bits of pages lo <= p < hi within word at wb
   function automatic logic [63:0] span(input logic [XW-1:0] lo, input logic [XW-1:0] hi,
                                        input logic [XW-1:0] wb);
      return below(kclamp(hi, wb)) & ~below(kclamp(lo, wb));
   endfunction

   state_type     state_ff, state_in;
   logic [AW-1:0] w_ff, w_in;
   logic [5:0]    j_ff, j_in;
   logic [13:0]   run_ff, run_in;
   logic [XW-1:0] start_ff, start_in;
   logic [XW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [63:0]   a_ff, a_in;
   logic [12:0]   rem_ff, rem_in;
   logic [12:0]   cnt_ff, cnt_in;
   logic [1:0]    status_ff, status_in;
   logic [63:0]   addr_ff, addr_in;
   logic [12:0]   bad_ff, bad_in, dbl_ff, dbl_in, free_ff, free_in;
   logic          resp_ff, resp_in;
   logic          ge_ff, ge_in;
   logic [63:0]   d_ff, d_in;
   logic [63:0]   sa_ff, sa_in;
   logic          empty_ff, empty_in;
   logic [63:0]   word_ff, word_in;

   logic [XW-1:0] pc, wb, nwb, page, found_start;
   logic [31:0]   pc32;
   logic [63:0]   fw, sp64, n64, pg64;
   logic [64:0]   sum65;
   logic [63:0]   e64;
   logic [XW-1:0] remp;
   logic [13:0]   run_nx;

   // effective page count
   assign pc32 = ({19'd0, cfg.page_count} > 32'(MAX_PAGES)) ? 32'(MAX_PAGES)
                                                            : {19'd0, cfg.page_count};
   assign pc   = XW'(pc32);
   assign wb   = {1'b0, w_ff, 6'd0};
   assign nwb  = wb + XW'(WORD_BITS);
   assign page = wb + XW'(j_ff);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff; w_in = w_ff; j_in = j_ff; run_in = run_ff;
      start_in = start_ff; lo_in = lo_ff; hi_in = hi_ff; a_in = a_ff;
      rem_in = rem_ff; cnt_in = cnt_ff; status_in = status_ff; addr_in = addr_ff;
      bad_in = bad_ff; dbl_in = dbl_ff; free_in = free_ff; resp_in = resp_ff;
      ge_in = ge_ff; d_in = d_ff; sa_in = sa_ff; empty_in = empty_ff; word_in = word_ff;
      mem_rd_en = 1'b0; mem_rd_addr = w_ff;
      mem_wr_en = 1'b0; mem_wr_addr = w_ff; mem_wr_data = mem_rd_data;
      res_valid = 1'b0;
      fw = ~mem_rd_data & span('0, pc, wb);
      sp64 = d_ff >> PAGE_BITS;
      n64 = (d_ff >> PAGE_BITS) + 64'(|(d_ff & OFF_MASK));
      pg64 = d_ff >> PAGE_BITS;
      e64 = (PAGE_STRIDE - (d_ff & OFF_MASK)) & OFF_MASK;
      sum65 = {1'b0, cfg.region_base} + {1'b0, e64};
      remp = pc - lo_ff;
      run_nx = run_ff + 14'd1;
      found_start = (run_ff == 14'd0) ? page : start_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cnt_in = req.count; status_in = STAT_OK; addr_in = '0;
               bad_in = '0; dbl_in = '0; a_in = req.address; rem_in = req.count;
               run_in = '0; w_in = '0;
               priority if (req.action == ACT_INIT) begin
                  state_in = S_INIT0;
               end else if (req.action == ACT_ALLOC) begin
                  if (req.count == 13'd0) begin
                     status_in = STAT_ZERO; state_in = S_DONE;
                  end else begin
                     mem_rd_en = 1'b1; mem_rd_addr = '0; state_in = S_AEV;
                  end
               end else if (req.action == ACT_FREE) begin
                  state_in = (req.count == 13'd0) ? S_DONE : S_FSUB;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         // init: locate first freed page
         S_INIT0: begin
            ge_in = cfg.free_from_addr >= cfg.region_base;
            d_in = ge_in ? cfg.free_from_addr - cfg.region_base
                         : cfg.region_base - cfg.free_from_addr;
            state_in = S_INIT1;
         end
         S_INIT1: begin
            if (ge_ff) begin
               sa_in = cfg.free_from_addr;
               empty_in = sp64 >= 64'(pc);
               lo_in = XW'(sp64);
            end else begin
               sa_in = sum65[63:0];
               empty_in = sum65[64] || (pc == '0);
               lo_in = '0;
            end
            state_in = S_INIT2;
         end
         S_INIT2: begin
            empty_in = empty_ff || (sa_ff >= cfg.free_to_addr);
            d_in = cfg.free_to_addr - sa_ff;
            state_in = S_INIT3;
         end
         S_INIT3: begin
            if (empty_ff) hi_in = lo_ff;
            else if (n64 < 64'(remp)) hi_in = lo_ff + XW'(n64);
            else hi_in = pc;
            free_in = 13'(hi_in - lo_ff);
            w_in = '0; resp_in = 1'b1;
            state_in = S_SWEEP;
         end
         // rewrite every word: used except the span
         S_SWEEP: begin
            mem_wr_en = 1'b1;
            mem_wr_data = ~span(lo_ff, hi_ff, wb);
            if (32'(w_ff) == WORDS - 1) begin
               state_in = resp_ff ? S_DONE : S_IDLE;
            end else begin
               w_in = w_ff + AW'(1);
            end
         end
         // alloc: evaluate one word
         S_AEV: begin
            if (fw == '0) begin
               run_in = '0;
            end else if (&fw) begin
               if (run_ff + 14'd64 >= {1'b0, cnt_ff}) begin
                  start_in = (run_ff == 14'd0) ? wb : start_ff;
               end else begin
                  if (run_ff == 14'd0) start_in = wb;
                  run_in = run_ff + 14'd64;
               end
            end else begin
               word_in = fw; j_in = '0;
            end
            if ((fw != '0) && (&fw) && (run_ff + 14'd64 >= {1'b0, cnt_ff})) begin
               lo_in = start_in; hi_in = start_in + XW'(cnt_ff);
               w_in = AW'(start_in >> 6); free_in = free_ff - cnt_ff;
               state_in = S_MRD;
            end else if ((fw != '0) && !(&fw)) begin
               state_in = S_ABIT;
            end else if (nwb >= pc) begin
               status_in = STAT_NOFIT; state_in = S_DONE;
            end else begin
               w_in = w_ff + AW'(1);
               mem_rd_en = 1'b1; mem_rd_addr = w_in;
            end
         end
         // alloc: step bit by bit through a mixed word
         S_ABIT: begin
            j_in = j_ff + 6'd1;
            if (word_ff[j_ff]) begin
               start_in = found_start; run_in = run_nx;
            end else begin
               run_in = '0;
            end
            if (word_ff[j_ff] && (run_nx == {1'b0, cnt_ff})) begin
               lo_in = found_start; hi_in = found_start + XW'(cnt_ff);
               w_in = AW'(found_start >> 6); free_in = free_ff - cnt_ff;
               state_in = S_MRD;
            end else if (j_ff == 6'd63) begin
               if (nwb >= pc) begin
                  status_in = STAT_NOFIT; state_in = S_DONE;
               end else begin
                  w_in = w_ff + AW'(1);
                  mem_rd_en = 1'b1; mem_rd_addr = w_in;
                  state_in = S_AEV;
               end
            end
         end
         // alloc: mark the run used, read-modify-write per word
         S_MRD: begin
            mem_rd_en = 1'b1;
            addr_in = cfg.region_base + (64'(lo_ff) << PAGE_BITS);
            state_in = S_MWR;
         end
         S_MWR: begin
            mem_wr_en = 1'b1;
            mem_wr_data = mem_rd_data | span(lo_ff, hi_ff, wb);
            if (nwb >= hi_ff) begin
               state_in = S_DONE;
            end else begin
               w_in = w_ff + AW'(1); state_in = S_MRD;
            end
         end
         // free: one page per pass
         S_FSUB: begin
            ge_in = a_ff >= cfg.region_base;
            d_in = a_ff - cfg.region_base;
            state_in = S_FCHK;
         end
         S_FCHK: begin
            if (ge_ff && (pg64 < 64'(pc))) begin
               start_in = XW'(pg64);
               mem_rd_en = 1'b1; mem_rd_addr = AW'(pg64 >> 6);
               w_in = mem_rd_addr;
               state_in = S_FUPD;
            end else begin
               bad_in = bad_ff + 13'd1;
               a_in = a_ff + PAGE_STRIDE; rem_in = rem_ff - 13'd1;
               state_in = (rem_ff == 13'd1) ? S_DONE : S_FSUB;
            end
         end
         S_FUPD: begin
            if (mem_rd_data[start_ff[5:0]]) begin
               mem_wr_en = 1'b1;
               mem_wr_data = mem_rd_data & ~(64'(1) << start_ff[5:0]);
               free_in = free_ff + 13'd1;
            end else begin
               dbl_in = dbl_ff + 13'd1;
            end
            a_in = a_ff + PAGE_STRIDE; rem_in = rem_ff - 13'd1;
            state_in = (rem_ff == 13'd1) ? S_DONE : S_FSUB;
         end
         // hand the result beat over
         S_DONE: begin
            if (res_ok) begin
               res_valid = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign res.result_address = addr_ff;
   assign res.status         = status_ff;
   assign res.invalid_pages  = bad_ff;
   assign res.double_frees   = dbl_ff;
   assign res.free_total     = free_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         w_ff     <= '0;
         lo_ff    <= '0;
         hi_ff    <= '0;
         free_ff  <= '0;
         resp_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         w_ff     <= w_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         free_ff  <= free_in;
         resp_ff  <= (state_in == S_IDLE) ? 1'b0 : resp_in;
      end
      j_ff <= j_in; run_ff <= run_in; start_ff <= start_in; a_ff <= a_in;
      rem_ff <= rem_in; cnt_ff <= cnt_in; status_ff <= status_in; addr_ff <= addr_in;
      bad_ff <= bad_in; dbl_ff <= dbl_in; ge_ff <= ge_in; d_ff <= d_in;
      sa_ff <= sa_in; empty_ff <= empty_in; word_ff <= word_in;
   end
endmodule

// File: verif/bitmap_page_allocator_check.sv
`timescale 1ns / 100ps

module bitmap_page_allocator_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  bpa_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  bpa_pkg::rsp_type rsp_payload,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_wdata,
   output int               fail_count,
   output int               pending
);
   import bpa_pkg::*;

   localparam int          MAP_PAGES   = 4096;
   localparam logic [63:0] PAGE_STRIDE = 64'd4096;
   localparam logic [63:0] OFF_MASK    = 64'hFFF;

   // shadow of the page map, free count and registers
   bit [MAP_PAGES-1:0] used_map;
   int unsigned        free_cnt;
   logic [63:0]        base_r, from_r, to_r;
   logic [12:0]        pages_r;
   rsp_type            expected_rsps[$];

   function automatic logic [63:0] live_pages();
      return (pages_r > MAP_PAGES) ? 64'(MAP_PAGES) : 64'(pages_r);
   endfunction

   // mark all used, then release the init window that falls in the region
   function automatic void rebuild_map();
      logic [63:0] pc, start_addr, start_page, d, e, span, n, last;
      used_map = '1;
      free_cnt = 0;
      pc = live_pages();
      if (from_r >= base_r) begin
         start_addr = from_r;
         start_page = (from_r - base_r) >> 12;
      end else begin
         d = base_r - from_r;
         e = (PAGE_STRIDE - (d & OFF_MASK)) & OFF_MASK;
         if (base_r > ~e) return;
         start_addr = base_r + e;
         start_page = 0;
      end
      if (start_addr >= to_r || start_page >= pc) return;
      span = to_r - start_addr;
      n = (span >> 12) + ((span & OFF_MASK) != 0 ? 64'd1 : 64'd0);
      last = (n < pc - start_page) ? start_page + n : pc;
      for (logic [63:0] i = start_page; i < last; i++) begin
         used_map[i[11:0]] = 1'b0;
         free_cnt++;
      end
   endfunction

   // lowest run of cnt free pages
   function automatic void take_run(input int unsigned cnt, output logic [63:0] addr,
                                    output logic [1:0] st);
      int unsigned pc, run, start;
      pc = 32'(live_pages());
      run = 0;
      start = 0;
      addr = '0;
      st = STAT_NOFIT;
      if (cnt == 0) begin
         st = STAT_ZERO;
         return;
      end
      for (int unsigned p = 0; p < pc; p++) begin
         if (used_map[p]) begin
            run = 0;
         end else begin
            if (run == 0) start = p;
            run++;
            if (run == cnt) begin
               for (int unsigned i = 0; i < cnt; i++) used_map[start + i] = 1'b1;
               free_cnt -= cnt;
               addr = base_r + (64'(start) << 12);
               st = STAT_OK;
               return;
            end
         end
      end
   endfunction

   function automatic void release_run(input logic [63:0] addr, input int unsigned cnt,
                                       output int unsigned bad, output int unsigned dbl);
      logic [63:0] a, p, pc;
      pc = live_pages();
      bad = 0;
      dbl = 0;
      for (int unsigned i = 0; i < cnt; i++) begin
         a = addr + (64'(i) << 12);
         if (a < base_r) begin
            bad++;
         end else begin
            p = (a - base_r) >> 12;
            if (p >= pc) bad++;
            else if (!used_map[p[11:0]]) dbl++;
            else begin
               used_map[p[11:0]] = 1'b0;
               free_cnt++;
            end
         end
      end
   endfunction

   function automatic rsp_type predict_rsp(input req_type rq);
      rsp_type     r;
      int unsigned bad, dbl;
      r = '0;
      bad = 0;
      dbl = 0;
      case (rq.action)
         ACT_INIT:  rebuild_map();
         ACT_ALLOC: take_run(32'(rq.count), r.result_address, r.status);
         ACT_FREE: begin
            release_run(rq.address, 32'(rq.count), bad, dbl);
         end
         default: ;
      endcase
      r.invalid_pages = bad[12:0];
      r.double_frees  = dbl[12:0];
      r.free_total    = free_cnt[12:0];
      return r;
   endfunction

   assign pending = expected_rsps.size();

   // track registers, predict on each request beat, compare each response beat
   always @(posedge clock) begin
      rsp_type want;
      bit      bad_beat;
      if (reset) begin
         used_map = '1;
         free_cnt = 0;
         base_r = '0;
         pages_r = '0;
         from_r = '0;
         to_r = '0;
         expected_rsps.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_REGION_BASE: base_r  = csr_wdata;
               CSR_PAGE_COUNT:  pages_r = csr_wdata[12:0];
               CSR_FREE_FROM:   from_r  = csr_wdata;
               CSR_FREE_TO:     to_r    = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_rsps.push_back(predict_rsp(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected response beat %p", $time, rsp_payload);
            end else begin
               want = expected_rsps.pop_front();
               bad_beat = (want.result_address != rsp_payload.result_address)
                       || (want.status != rsp_payload.status)
                       || (want.invalid_pages != rsp_payload.invalid_pages)
                       || (want.double_frees != rsp_payload.double_frees)
                       || (want.free_total != rsp_payload.free_total);
               if (bad_beat) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: response mismatch, expected %p, got %p",
                              $time, want, rsp_payload);
               end
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

// File: verif/bitmap_page_allocator_test.sv
`timescale 1ns / 100ps

module bitmap_page_allocator_test;
   import bpa_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_REGION_BASE;
   logic [63:0] csr_wdata = '0;
   int          fail_count;
   int          pending;

   int          idle_pct = 0;
   int          stall_pct = 0;
   bit          hold_req = 0;
   int          hold_cnt = 0;
   int          n_init = 0, n_alloc = 0, n_free = 0, n_other = 0;
   logic [63:0] cur_base;
   int unsigned cur_pages;

   localparam int PHASES = 8;
   int phase_items[PHASES] = '{220, 240, 150, 200, 150, 240, 200, 230};

   bitmap_page_allocator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   bitmap_page_allocator_check checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   always #5 clock = ~clock;

   // response side: random stall, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_req) begin
         rsp_stall <= 1'b1;
         hold_cnt++;
         if (hold_cnt == 400) begin
            hold_req = 0;
            hold_cnt = 0;
         end
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic send_beat(input logic [1:0] act, input logic [63:0] addr,
                            input logic [12:0] cnt);
      req_type rq;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      rq.action = act;
      rq.address = addr;
      rq.count = cnt;
      req_valid <= 1'b1;
      req_payload <= rq;
      do @(posedge clock); while (req_stall);
      case (act)
         ACT_INIT:  n_init++;
         ACT_ALLOC: n_alloc++;
         ACT_FREE:  n_free++;
         default:   n_other++;
      endcase
   endtask

   // hold the sender until every response is in
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input logic [63:0] base, input logic [63:0] pages,
                             input logic [63:0] from, input logic [63:0] to);
      logic [63:0] vals[4];
      vals = '{base, pages, from, to};
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= 2'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      cur_base = base;
      cur_pages = (pages[12:0] > 13'd4096) ? 32'd4096 : 32'(pages[12:0]);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic set_phase(input int ph);
      logic [63:0] b;
      case (ph)
         0: write_regs(64'd0, 64'd64, 64'd0, 64'd64 << 12);
         1: begin
            b = 64'h8000_0000;
            write_regs(b, 64'd300, b + 64'h3000, b + (64'd200 << 12) + 64'd5);
         end
         2: begin
            b = {rand64()} & ~64'hFFF;
            write_regs(b, 64'd4096, b - 64'h1800, '1);
         end
         3: begin
            b = 64'hFFFF_FFFF_FFF0_0000;
            write_regs(b, 64'h1FFF, b, '1);
         end
         4: write_regs(rand64(), 64'd0, rand64(), rand64());
         5: write_regs(rand64(), 64'($urandom_range(0, 8191)), rand64(), rand64());
         6: write_regs('1, 64'd100, 64'hFFFF_FFFF_FFFF_0000, '1);
         default: write_regs(64'h1000, 64'd1, 64'd0, 64'h1001);
      endcase
   endtask

   // mostly allocs and frees aimed at the region, some noise
   task automatic random_beat();
      int          r;
      logic [63:0] addr;
      logic [12:0] cnt;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         send_beat(ACT_INIT, rand64(), 13'($urandom));
      end else if (r < 48) begin
         r = $urandom_range(0, 99);
         if (r < 5) cnt = 0;
         else if (r < 10) cnt = 13'($urandom_range(1, cur_pages + 2));
         else if (r < 12) cnt = 13'($urandom_range(4096, 8191));
         else cnt = 13'($urandom_range(1, 8));
         send_beat(ACT_ALLOC, rand64(), cnt);
      end else if (r < 95) begin
         if ($urandom_range(0, 99) < 80) begin
            addr = cur_base + (64'($urandom_range(0, cur_pages + 3)) << 12);
            if ($urandom_range(0, 9) == 0) addr = addr + 64'($urandom_range(0, 4095));
         end else begin
            addr = rand64();
         end
         cnt = ($urandom_range(0, 99) == 0) ? 13'($urandom_range(4096, 8191))
                                            : 13'($urandom_range(0, 8));
         send_beat(ACT_FREE, addr, cnt);
      end else if (r < 98) begin
         send_beat(ACT_NOP, rand64(), 13'($urandom));
      end else begin
         send_beat(2'($urandom_range(0, 3)), rand64(), 13'($urandom));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int ph = 0; ph < PHASES; ph++) begin
         set_phase(ph);
         send_beat(ACT_INIT, '0, '0);
         if (ph == 0) begin
            // corner cases on a one-word region
            send_beat(ACT_ALLOC, '1, 13'd0);
            send_beat(ACT_ALLOC, '0, 13'd1);
            send_beat(ACT_ALLOC, '0, 13'd64);
            send_beat(ACT_ALLOC, '0, 13'd63);
            send_beat(ACT_ALLOC, '0, 13'd1);
            send_beat(ACT_FREE, 64'h0, 13'd0);
            send_beat(ACT_FREE, 64'h0, 13'd1);
            send_beat(ACT_FREE, 64'h0, 13'd1);
            send_beat(ACT_FREE, 64'hFFFF_FFFF_FFFF_F000, 13'd3);
            send_beat(ACT_FREE, 64'h5FFF, 13'd2);
            send_beat(ACT_ALLOC, '0, 13'd4096);
            send_beat(ACT_ALLOC, '0, 13'h1FFF);
            send_beat(ACT_FREE, 64'd64 << 12, 13'd2);
            send_beat(ACT_FREE, 64'h0, 13'd64);
            send_beat(ACT_ALLOC, '0, 13'd64);
            send_beat(ACT_NOP, '1, 13'h1FFF);
            send_beat(ACT_FREE, 64'h0, 13'h1FFF);
            send_beat(ACT_INIT, '1, 13'h1FFF);
            send_beat(ACT_ALLOC, '0, 13'd2);
         end
         for (int k = 0; k < phase_items[ph]; k++) begin
            // idle pattern rotates per phase, with stretches of none
            if ((k / 40) % 3 == 2) begin
               idle_pct = 0;
               stall_pct = 0;
            end else begin
               case (ph % 4)
                  0: begin idle_pct = 0;  stall_pct = 0;  end
                  1: begin idle_pct = 81; stall_pct = 0;  end
                  2: begin idle_pct = 0;  stall_pct = 81; end
                  default: begin idle_pct = 27; stall_pct = 27; end
               endcase
            end
            if (ph == 1 && k == 60) hold_req = 1;
            if (ph == 2 && k == 70) drain();
            random_beat();
         end
         idle_pct = 0;
         drain();
      end
      stall_pct = 0;
      repeat (100) @(posedge clock);
      $display("Covered %0d phases of region settings: %0d init, %0d alloc, %0d free, %0d other",
               PHASES, n_init, n_alloc, n_free, n_other);
      $display("beats, under mixed sender gaps and response stalls.");
      if (fail_count == 0 && pending == 0) begin
         $display("bitmap_page_allocator verification clean");
      end else begin
         $display("bitmap_page_allocator verification failed");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("bitmap_page_allocator verification failed");
      $finish;
   end

endmodule
